### rtl/core/fvn_pkg.sv
// Package for the fractal value noise block: constants, state codes and helpers.
package fvn_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int OCTAVE_MAX_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PROD_FRAC      = 24;
    localparam int OUT_BITS       = 16;
    localparam int TDATA_W        = 88;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] REG_SEED  = 2'd0;
    localparam logic [1:0] REG_FREQ  = 2'd1;
    localparam logic [1:0] REG_OCT   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_OCT_START,
        ST_RD_Y,
        ST_WAIT_Y,
        ST_RD_X,
        ST_WAIT_X,
        ST_SQ,
        ST_POLY,
        ST_WGT,
        ST_BLEND_LO,
        ST_BLEND_HI,
        ST_BLEND_V,
        ST_ACCUM,
        ST_DIV,
        ST_OUT
    } fvn_state_t;

endpackage

### rtl/core/fvn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/fractal_value_noise_2d_top.sv
// Top level of the fractal value noise block: sequencer, shared multiplier, divider.
// A table-write transaction is accepted in idle and written to the RAM on acceptance.
// One sample transaction goes through these steps from acceptance until its result is offered:
// - coordinate scaling, x then y, on the signed coordinate multiplier;
// - per octave, one setup state, then the table reads for four corners. Each corner makes two
//   dependent reads of the table RAM's single read port, and each read is a read state
//   plus a wait state for the registered data;
// - per octave, smoothstep weights for x then y and three blends on the single
//   shared multiplier, then one accumulate step;
// - a one-bit-per-cycle restoring divider for the final normalization (NUM_W steps,
//   40 with the default parameters), then an output state.
// The block accepts no input while it works. The result waits in an output register,
// and a new transaction may enter while it waits. The octave count is latched at
// acceptance; seed and frequency are read live while the sample is worked.
module fractal_value_noise_2d_top
    import fvn_pkg::*;
#(
    parameter int TABLE_SIZE = fvn_pkg::TABLE_SIZE_DEF,
    parameter int OCTAVE_MAX = fvn_pkg::OCTAVE_MAX_DEF,
    parameter int FRAC_BITS  = fvn_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // tdata: opcode[0], table_index[8:1], table_value[16:9], x_coord[48:17],
    // y_coord[80:49], zero fill [87:81]
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fvn_pkg::TDATA_W-1:0] s_tdata,
    // tdata: noise_value[15:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int OCT_W = $clog2(OCTAVE_MAX + 1);
    localparam int VAL_W = 8 + FRAC_BITS;                  // Q8.F blend values
    localparam int SUM_W = VAL_W + OCTAVE_MAX;
    localparam int NUM_W = SUM_W + OUT_BITS - 8;
    localparam int DEN_W = OCTAVE_MAX + FRAC_BITS;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W = $clog2(DIV_STEPS + 1);
    localparam int MUL_W = 2 * VAL_W;                      // product width used
    localparam int CRD_W = PROD_FRAC + 8 + OCTAVE_MAX;     // scaled coordinate kept bits

    // ---------------- configuration ----------------
    logic [7:0]  seed_reg;
    logic [15:0] freq_reg;
    logic [3:0]  oct_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 8'd0;
            freq_reg <= 16'd256;
            oct_reg  <= 4'd4;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SEED: seed_reg <= pwdata[7:0];
                REG_FREQ: freq_reg <= pwdata[15:0];
                REG_OCT:  oct_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SEED: prdata = {24'd0, seed_reg};
            REG_FREQ: prdata = {16'd0, freq_reg};
            REG_OCT:  prdata = {28'd0, oct_reg};
            default:  prdata = 32'd0;
        endcase
    end

    // ---------------- registers ----------------
    fvn_state_t state_reg, state_next;
    logic [CRD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0]       xcrd_reg, xcrd_next;               // x coordinate of the transaction
    logic [31:0]       ycrd_reg, ycrd_next;
    logic [OCT_W-1:0]  d_reg, d_next, oi_reg, oi_next;
    logic [1:0]        corner_reg, corner_next;
    logic [7:0]        c_reg [4];
    logic [7:0]        c_next [4];
    logic [FRAC_BITS:0]   wxs_reg, wxs_next;              // x weight saved
    logic [FRAC_BITS:0]   wys_reg, wys_next;              // y weight saved
    logic              wsel_reg, wsel_next;               // 0: x weight, 1: y weight
    logic [MUL_W-1:0]  t_reg, t_next;                     // product scratch
    logic [VAL_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [NUM_W-1:0]  rem_reg, rem_next, quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [15:0]       out_reg, out_next;
    logic              mval_reg, mval_next;
    logic [IDX_W-1:0]  raddr;
    logic [7:0]        rdata;
    logic              ram_we;

    // ---------------- shared multiplier ----------------
    logic [MUL_W/2-1:0] mul_a;
    logic [MUL_W/2-1:0] mul_b;
    logic [32:0]        mul_sa;
    logic [MUL_W-1:0]   mul_p;
    logic signed [48:0] smul_p;

    assign mul_p  = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign smul_p = $signed(mul_sa) * $signed({1'b0, freq_reg});

    // ---------------- helpers ----------------
    logic [FRAC_BITS-1:0] xf, yf, sel_f;
    logic [7:0] xi, yi;
    logic [CRD_W-1:0] cxs, cys;
    logic [VAL_W-1:0] ba, bb, bdiff, bres;
    logic             bge;
    logic [DEN_W-1:0] den;
    logic [NUM_W:0]   rtry;

    assign cxs = cx_reg << oi_reg;
    assign cys = cy_reg << oi_reg;
    assign xi  = cxs[PROD_FRAC +: 8];
    assign yi  = cys[PROD_FRAC +: 8];
    assign xf  = cxs[PROD_FRAC-FRAC_BITS +: FRAC_BITS];
    assign yf  = cys[PROD_FRAC-FRAC_BITS +: FRAC_BITS];
    assign sel_f = wsel_reg ? yf : xf;
    assign den = DEN_W'(((DEN_W'(1) << d_reg) - DEN_W'(1)) << FRAC_BITS);
    assign rtry = {rem_reg, quo_reg[NUM_W-1]} - (NUM_W+1)'(den);

    always_comb begin
        case (state_reg)
            ST_BLEND_LO: begin ba = {c_reg[0], {FRAC_BITS{1'b0}}};
                                bb = {c_reg[1], {FRAC_BITS{1'b0}}}; end
            ST_BLEND_HI: begin ba = {c_reg[2], {FRAC_BITS{1'b0}}};
                                bb = {c_reg[3], {FRAC_BITS{1'b0}}}; end
            default:     begin ba = lo_reg; bb = hi_reg; end
        endcase
    end
    assign bge   = bb >= ba;
    assign bdiff = bge ? bb - ba : ba - bb;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sa = '0;
        case (state_reg)
            ST_SCALE_X: mul_sa = {xcrd_reg[31], xcrd_reg};
            ST_SCALE_Y: mul_sa = {ycrd_reg[31], ycrd_reg};
            ST_SQ: begin
                mul_a = (MUL_W/2)'(sel_f);
                mul_b = (MUL_W/2)'(sel_f);
            end
            ST_POLY: begin
                mul_a = (MUL_W/2)'(t_reg[FRAC_BITS +: FRAC_BITS]);
                mul_b = (MUL_W/2)'(((FRAC_BITS+2)'(3) << FRAC_BITS)
                        - ((FRAC_BITS+2)'(sel_f) << 1));
            end
            ST_BLEND_LO, ST_BLEND_HI: begin
                mul_a = (MUL_W/2)'(wxs_reg);
                mul_b = (MUL_W/2)'(bdiff);
            end
            ST_BLEND_V: begin
                mul_a = (MUL_W/2)'(wys_reg);
                mul_b = (MUL_W/2)'(bdiff);
            end
            default: ;
        endcase
    end

    logic [VAL_W-1:0] bstep;
    assign bstep = VAL_W'(mul_p >> FRAC_BITS);
    assign bres  = bge ? ba + bstep : ba - bstep;

    // ---------------- table RAM ----------------
    assign ram_we = s_tvalid && s_tready && (s_tdata[0] == OP_WRITE);

    fvn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_tdata[1 +: IDX_W]),
        .wdata (s_tdata[16:9]),
        .raddr (raddr),
        .rdata (rdata)
    );

    // corner offsets: 0 (x,y) 1 (x+1,y) 2 (x,y+1) 3 (x+1,y+1)
    logic [7:0] cyi, cxi;
    assign cyi = yi + 8'(corner_reg[1]) + seed_reg;
    assign cxi = rdata + xi + 8'(corner_reg[0]);

    always_comb begin
        case (state_reg)
            ST_RD_X, ST_WAIT_X: raddr = IDX_W'(cxi);
            default:            raddr = IDX_W'(cyi);
        endcase
    end

    // ---------------- sequencer ----------------
    // Accept in idle even while a result waits; the output register holds it.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        state_next  = state_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        ycrd_next   = ycrd_reg;
        xcrd_next   = xcrd_reg;
        d_next      = d_reg;
        oi_next     = oi_reg;
        corner_next = corner_reg;
        c_next      = c_reg;
        wxs_next    = wxs_reg;
        wys_next    = wys_reg;
        wsel_next   = wsel_reg;
        t_next      = t_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sum_next    = sum_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dcnt_next   = dcnt_reg;
        out_next    = out_reg;
        mval_next   = mval_reg;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready && s_tdata[0] == OP_SAMPLE) begin
                    xcrd_next = s_tdata[48:17];
                    ycrd_next = s_tdata[80:49];
                    if (oct_reg == 4'd0)
                        d_next = OCT_W'(1);
                    else if (32'(oct_reg) > OCTAVE_MAX)
                        d_next = OCT_W'(OCTAVE_MAX);
                    else
                        d_next = OCT_W'(oct_reg);
                    state_next = ST_SCALE_X;
                end
            end
            ST_SCALE_X: begin
                cx_next    = CRD_W'(smul_p);
                state_next = ST_SCALE_Y;
            end
            ST_SCALE_Y: begin
                cy_next    = CRD_W'(smul_p);
                oi_next    = '0;
                sum_next   = '0;
                state_next = ST_OCT_START;
            end
            ST_OCT_START: begin
                corner_next = 2'd0;
                wsel_next   = 1'b0;
                state_next  = ST_RD_Y;
            end
            ST_RD_Y:   state_next = ST_WAIT_Y;        // address presented
            ST_WAIT_Y: state_next = ST_RD_X;          // first-level byte now in rdata
            ST_RD_X:   state_next = ST_WAIT_X;
            ST_WAIT_X: begin
                c_next[corner_reg] = rdata;
                corner_next = corner_reg + 2'd1;
                state_next  = (corner_reg == 2'd3) ? ST_SQ : ST_RD_Y;
            end
            ST_SQ: begin
                t_next     = mul_p;
                state_next = ST_POLY;
            end
            ST_POLY: begin
                t_next     = mul_p;
                state_next = ST_WGT;
            end
            ST_WGT: begin
                if (!wsel_reg) begin
                    wxs_next  = (FRAC_BITS+1)'(t_reg >> FRAC_BITS);
                    wsel_next = 1'b1;
                    state_next = ST_SQ;
                end else begin
                    wys_next   = (FRAC_BITS+1)'(t_reg >> FRAC_BITS);
                    state_next = ST_BLEND_LO;
                end
            end
            ST_BLEND_LO: begin
                lo_next    = bres;
                state_next = ST_BLEND_HI;
            end
            ST_BLEND_HI: begin
                hi_next    = bres;
                state_next = ST_BLEND_V;
            end
            ST_BLEND_V: begin
                lo_next    = bres;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                sum_next = sum_reg + (SUM_W'(lo_reg) << (d_reg - oi_reg - OCT_W'(1)));
                if (oi_reg == d_reg - OCT_W'(1)) begin
                    state_next = ST_DIV;
                    rem_next   = '0;
                    quo_next   = NUM_W'(sum_next) << (OUT_BITS - 8);
                    dcnt_next  = '0;
                end else begin
                    oi_next    = oi_reg + OCT_W'(1);
                    state_next = ST_OCT_START;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!rtry[NUM_W]) begin
                    rem_next = rtry[NUM_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[NUM_W-2:0], quo_reg[NUM_W-1]};
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free or drains this cycle
                if (!mval_reg || m_tready) begin
                    out_next   = quo_reg[15:0];
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        ycrd_reg      <= ycrd_next;
        xcrd_reg      <= xcrd_next;
        d_reg         <= d_next;
        oi_reg        <= oi_next;
        corner_reg    <= corner_next;
        c_reg         <= c_next;
        wxs_reg       <= wxs_next;
        wys_reg       <= wys_next;
        wsel_reg      <= wsel_next;
        t_reg         <= t_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dcnt_reg      <= dcnt_next;
        out_reg       <= out_next;
    end
endmodule

### verif/fractal_value_noise_2d_top_tb.sv
// Testbench for the fractal value noise block: stream stimulus, APB setup, result checking.
module fractal_value_noise_2d_top_tb;
    import fvn_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int DRAIN_CYCLES = 400;   // settling margin after the last result is drained

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    fractal_value_noise_2d_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Shadow state of the block.
    logic [7:0]  perm_shadow [TABLE_SIZE_DEF];
    logic [7:0]  seed_shadow = 8'd0;
    logic [15:0] freq_shadow = 16'd256;
    logic [3:0]  oct_shadow  = 4'd4;

    logic [15:0] noise_expected [$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;

    // ---------------- noise predictor ----------------
    function automatic longint unsigned corner_byte(longint unsigned xi, longint unsigned yi);
        longint unsigned yidx;
        longint unsigned xidx;
        yidx = (yi + seed_shadow) & 64'd255;
        xidx = (perm_shadow[yidx] + xi) & 64'd255;
        return perm_shadow[xidx];
    endfunction

    function automatic longint unsigned smooth_mix(longint unsigned a, longint unsigned b,
                                                   longint unsigned s);
        longint unsigned s2;
        longint unsigned w;
        s2 = (s * s) >> FRAC_BITS_DEF;
        w  = (s2 * ((64'd3 << FRAC_BITS_DEF) - 64'd2 * s)) >> FRAC_BITS_DEF;
        if (b >= a)
            return a + ((w * (b - a)) >> FRAC_BITS_DEF);
        return a - ((w * (a - b)) >> FRAC_BITS_DEF);
    endfunction

    function automatic longint unsigned octave_sample(longint unsigned cx, longint unsigned cy);
        longint unsigned xi, yi, xf, yf, c00, c10, c01, c11, lo, hi;
        xi  = (cx >> PROD_FRAC) & 64'hFF;
        yi  = (cy >> PROD_FRAC) & 64'hFF;
        xf  = (cx >> (PROD_FRAC - FRAC_BITS_DEF)) & 64'hFFFF;
        yf  = (cy >> (PROD_FRAC - FRAC_BITS_DEF)) & 64'hFFFF;
        c00 = corner_byte(xi, yi) << FRAC_BITS_DEF;
        c10 = corner_byte(xi + 1, yi) << FRAC_BITS_DEF;
        c01 = corner_byte(xi, yi + 1) << FRAC_BITS_DEF;
        c11 = corner_byte(xi + 1, yi + 1) << FRAC_BITS_DEF;
        lo  = smooth_mix(c00, c10, xf);
        hi  = smooth_mix(c01, c11, xf);
        return smooth_mix(lo, hi, yf);
    endfunction

    function automatic logic [15:0] fractal_noise(logic [31:0] x, logic [31:0] y);
        longint unsigned px, py, total, denom, q;
        int d;
        d = oct_shadow;
        if (d == 0) d = 1;
        if (d > OCTAVE_MAX_DEF) d = OCTAVE_MAX_DEF;
        px = {{32{x[31]}}, x} * {48'd0, freq_shadow};
        py = {{32{y[31]}}, y} * {48'd0, freq_shadow};
        total = 0;
        for (int i = 0; i < d; i++)
            total += octave_sample(px << i, py << i) << (d - 1 - i);
        denom = ((64'd1 << d) - 1) << FRAC_BITS_DEF;
        q = (total << (OUT_BITS - 8)) / denom;
        return q[15:0];
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (noise_expected.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            else if (m_tdata !== noise_expected[0]) begin
                report_mismatch($sformatf("noise_value got %h want %h",
                                          m_tdata, noise_expected[0]));
                void'(noise_expected.pop_front());
            end else
                void'(noise_expected.pop_front());
        end
    end

    // Receiver: periodically pick a new stall style and period at random.
    int rx_mode = 0;
    int rx_count = 0;
    int rx_period = 3;
    always @(posedge aclk) begin
        rx_count++;
        if (rx_count % 250 == 0) begin
            rx_mode   = $urandom_range(0, 3);
            rx_period = $urandom_range(2, 8);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (rx_count % rx_period == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_item(input logic [TDATA_W-1:0] item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        // Update the shadow on acceptance.
        if (item[0] == OP_WRITE)
            perm_shadow[item[8:1]] = item[16:9];
        else
            noise_expected.push_back(fractal_noise(item[48:17], item[80:49]));
    endtask

    task automatic send_write(input logic [7:0] idx, input logic [7:0] val);
        send_item({7'd0, 32'd0, 32'd0, val, idx, OP_WRITE});
    endtask

    task automatic send_sample(input logic [31:0] x, input logic [31:0] y);
        send_item({7'd0, y, x, 16'd0, OP_SAMPLE});
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SEED: seed_shadow = val[7:0];
            REG_FREQ: freq_shadow = val[15:0];
            default:  oct_shadow  = val[3:0];
        endcase
    endtask

    // Drain outstanding results, then let the block settle before touching registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (noise_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] sd, input logic [15:0] fr, input logic [3:0] oc);
        wait_idle();
        apb_write(REG_SEED, {24'd0, sd});
        apb_write(REG_FREQ, {16'd0, fr});
        apb_write(REG_OCT, {28'd0, oc});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: return $urandom_range(0, 32'h00FF_FFFF);
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_table_load();
        int order [TABLE_SIZE_DEF];
        int j, t;
        for (int i = 0; i < TABLE_SIZE_DEF; i++) order[i] = i;
        for (int i = TABLE_SIZE_DEF - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        // Load every entry, in shuffled order, before any sample.
        for (int i = 0; i < TABLE_SIZE_DEF; i++)
            send_write(order[i][7:0], 8'($urandom()));
    endtask

    task automatic test_extremes();
        // Reset register values first.
        send_sample(32'd0, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF, 32'h0000_FFFF);
        send_sample(32'h0001_8000, 32'hFFFE_4000);
        set_config(8'd255, 16'd65535, 4'd8);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000);
        send_sample(32'h1234_5678, 32'hEDCB_A987);
        // Octaves zero acts as one.
        set_config(8'd0, 16'd1, 4'd0);
        send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0000_8000, 32'h0000_4000);
        // Octaves above the maximum saturate.
        set_config(8'd17, 16'd4096, 4'd15);
        send_sample(32'h0003_C000, 32'hFFFF_0001);
        send_sample(32'hABCD_0123, 32'h0000_0000);
        // Frequency zero samples the origin cell.
        set_config(8'd200, 16'd0, 4'd1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h0102_0304, 32'hF0E0_D0C0);
        set_config(8'd1, 16'd256, 4'd1);
        send_sample(32'h00FF_FFFF, 32'h00FF_FFFF);
        send_sample(32'h0000_0001, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_phases();
        logic [15:0] fr;
        for (int ph = 0; ph < 24; ph++) begin
            case ($urandom_range(0, 3))
                0: fr = 16'($urandom_range(1, 1024));
                1: fr = 16'($urandom());
                2: fr = ($urandom_range(0, 1) == 1) ? 16'd65535 : 16'd1;
                default: fr = 16'($urandom_range(128, 512));
            endcase
            set_config(8'($urandom()), fr, 4'($urandom_range(0, 15)));
            for (int n = 0; n < 40; n++) begin
                if ($urandom_range(0, 7) == 0)
                    send_write(8'($urandom()), 8'($urandom()));
                else
                    send_sample(rand_coord(), rand_coord());
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_table_load();
        test_extremes();
        test_random_phases();
        wait_idle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/core/fvn_pkg.sv
rtl/core/fvn_ram.sv
rtl/core/fractal_value_noise_2d_top.sv
verif/fractal_value_noise_2d_top_tb.sv
